### design/dtfx_pkg.sv
package dtfx_pkg;

  // Character codes the parser recognizes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam int MAN_W  = 64;
  localparam int FDIG_W = 5;

  // Parser phase
  typedef enum logic [1:0] {
    PH_DONE,
    PH_BLANK,
    PH_INT,
    PH_FRAC
  } phase_t;

  // Divider sequencer state
  typedef enum logic [2:0] {
    DV_IDLE,
    DV_DIVIDE,
    DV_ROUND,
    DV_CLAMP,
    DV_EMIT
  } div_state_t;

  // Finished number handed from parser to divider
  typedef struct packed {
    logic [MAN_W-1:0]  mantissa;
    logic [FDIG_W-1:0] fdigits;
    logic              negative;
    logic              saturated;
  } div_req_t;

  // Ten to the power n, for n up to 19
  function automatic logic [MAN_W-1:0] pow10(input logic [FDIG_W-1:0] n);
    logic [MAN_W-1:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

### design/dtfx_text_if.sv
interface dtfx_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       starts_string;

  modport source (output valid, output character, output starts_string, input ready);
  modport sink   (input valid, input character, input starts_string, output ready);
endinterface

### design/dtfx_result_if.sv
interface dtfx_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] number;
  logic               overflowed;

  modport source (output valid, output number, output overflowed, input ready);
  modport sink   (input valid, input number, input overflowed, output ready);
endinterface

### design/dtfx_divider.sv
module dtfx_divider
  import dtfx_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  div_req_t      req,
  output logic          busy,
  dtfx_result_if.source result
);

  localparam int TOTAL = MAN_W + FRAC_BITS;
  localparam int CNT_W = $clog2(TOTAL);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TOTAL - 1);

  div_state_t       state, state_next;
  logic [MAN_W-1:0] dividend, dividend_next;
  logic [MAN_W-1:0] rem, rem_next;
  logic [MAN_W-1:0] q, q_next;
  logic [MAN_W-1:0] divisor, divisor_next;
  logic             ovf, ovf_next;
  logic             negative, negative_next;
  logic [CNT_W-1:0] count, count_next;
  logic             emit;

  logic [MAN_W:0]   wide;
  logic [MAN_W:0]   diff;
  logic             take;
  logic [MAN_W-1:0] limit;

  // One restoring step: shift in the next dividend bit, compare, subtract
  always_comb begin
    wide = {rem, dividend[MAN_W-1]};
    diff = wide - {1'b0, divisor};
    take = (wide >= {1'b0, divisor});
    limit = negative ? {1'b1, {(MAN_W-1){1'b0}}} : {1'b0, {(MAN_W-1){1'b1}}};
  end

  // Sequence divide, round, clamp and emit
  always_comb begin
    state_next    = state;
    dividend_next = dividend;
    rem_next      = rem;
    q_next        = q;
    divisor_next  = divisor;
    ovf_next      = ovf;
    negative_next = negative;
    count_next    = count;
    emit          = 1'b0;
    unique case (state)
      DV_IDLE: begin
        if (start) begin
          dividend_next = req.mantissa;
          rem_next      = '0;
          q_next        = '0;
          divisor_next  = pow10(req.fdigits);
          ovf_next      = req.saturated;
          negative_next = req.negative;
          count_next    = '0;
          state_next    = DV_DIVIDE;
        end
      end
      DV_DIVIDE: begin
        rem_next      = take ? diff[MAN_W-1:0] : wide[MAN_W-1:0];
        ovf_next      = ovf | q[MAN_W-1];
        q_next        = {q[MAN_W-2:0], take};
        dividend_next = {dividend[MAN_W-2:0], 1'b0};
        count_next    = count + 1'b1;
        if (count == LAST) begin
          state_next = DV_ROUND;
        end
      end
      DV_ROUND: begin
        // Round half away from zero on the magnitude
        if ({rem, 1'b0} >= {1'b0, divisor}) begin
          if (&q) begin
            ovf_next = 1'b1;
          end else begin
            q_next = q + 1'b1;
          end
        end
        state_next = DV_CLAMP;
      end
      DV_CLAMP: begin
        if (ovf || q > limit) begin
          ovf_next = 1'b1;
          q_next   = limit;
        end
        state_next = DV_EMIT;
      end
      DV_EMIT: begin
        // Hold until the output register is free
        if (!result.valid || result.ready) begin
          emit       = 1'b1;
          state_next = DV_IDLE;
        end
      end
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
    dividend <= dividend_next;
    rem      <= rem_next;
    q        <= q_next;
    divisor  <= divisor_next;
    ovf      <= ovf_next;
    negative <= negative_next;
    count    <= count_next;
  end

  // Output register: load on emit, drop once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (emit) begin
      result.number     <= negative ? $signed(-q) : $signed(q);
      result.overflowed <= ovf;
    end
  end

  assign busy = (state != DV_IDLE);

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == DV_IDLE)
    else $error("divider started while busy");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == DV_ROUND |-> rem < divisor)
    else $error("remainder not below divisor after last step");
  a_clamped: assert property (@(posedge clk) disable iff (rst)
    state == DV_EMIT |-> q <= limit)
    else $error("magnitude above bound at emit");
  a_round_order: assert property (@(posedge clk) disable iff (rst)
    state == DV_ROUND |-> $past(state) == DV_DIVIDE)
    else $error("rounding entered out of order");
`endif

endmodule

### design/decimal_text_to_fixed_point.sv
// Channel  Role    Payload
// text     sink    character[7:0], starts_string
// result   source  number[63:0] signed, overflowed
//
// Characters are accepted whenever the divider is not busy.
// The character that ends a number starts the divider: 64 + FRAC_BITS
// restoring steps, then the round, clamp and emit states, during which
// text.ready is low, as it is whenever the divider is busy.
// rst is synchronous; after it characters are ignored until a start flag.
// A result waiting in the output register holds the next emit, and text.ready stays low meanwhile.
module decimal_text_to_fixed_point
  import dtfx_pkg::*;
#(
  parameter int FRAC_BITS           = 24,
  parameter int MAX_FRACTION_DIGITS = 18
) (
  input  logic          clk,
  input  logic          rst,
  dtfx_text_if.sink     text,
  dtfx_result_if.source result
);

  phase_t            phase, phase_next;
  logic              negative, negative_next;
  logic [MAN_W-1:0]  mantissa, mantissa_next;
  logic [FDIG_W-1:0] fraction_digits, fraction_digits_next;
  logic              mantissa_saturated, mantissa_saturated_next;

  phase_t            eph;
  logic              eneg;
  logic [MAN_W-1:0]  eman;
  logic [FDIG_W-1:0] efd;
  logic              esat;

  logic              accept;
  logic              is_digit, is_blank, is_sign, is_point;
  logic [MAN_W+3:0]  acc;
  logic [MAN_W-1:0]  added_man;
  logic              added_sat;
  logic              start;
  logic              div_busy;
  div_req_t          req;

  assign accept   = text.valid && text.ready;
  assign text.ready = !div_busy;

  // Classify the character
  always_comb begin
    is_digit = (text.character >= CH_ZERO) && (text.character <= CH_NINE);
    is_blank = (text.character == CH_SPACE) || (text.character == CH_NEWLINE) ||
               (text.character == CH_TAB);
    is_sign  = (text.character == CH_PLUS) || (text.character == CH_MINUS);
    is_point = (text.character == CH_POINT);
  end

  // Start flag restarts the number on its own character
  always_comb begin
    eph  = phase;
    eneg = negative;
    eman = mantissa;
    efd  = fraction_digits;
    esat = mantissa_saturated;
    if (text.starts_string) begin
      eph  = PH_BLANK;
      eneg = 1'b0;
      eman = '0;
      efd  = '0;
      esat = 1'b0;
    end
  end

  // Mantissa times ten plus digit, saturating
  always_comb begin
    acc = ({4'b0, eman} << 3) + ({4'b0, eman} << 1) +
          {{(MAN_W){1'b0}}, text.character[3:0]};
    added_man = eman;
    added_sat = esat;
    if (!esat) begin
      if (|acc[MAN_W+3:MAN_W]) begin
        added_man = '1;
        added_sat = 1'b1;
      end else begin
        added_man = acc[MAN_W-1:0];
      end
    end
  end

  // Parser next state
  always_comb begin
    phase_next              = phase;
    negative_next           = negative;
    mantissa_next           = mantissa;
    fraction_digits_next    = fraction_digits;
    mantissa_saturated_next = mantissa_saturated;
    start                   = 1'b0;
    if (accept) begin
      phase_next              = eph;
      negative_next           = eneg;
      mantissa_next           = eman;
      fraction_digits_next    = efd;
      mantissa_saturated_next = esat;
      unique case (eph)
        PH_DONE: begin
        end
        PH_BLANK: begin
          if (is_blank) begin
            phase_next = PH_BLANK;
          end else if (is_sign) begin
            negative_next = (text.character == CH_MINUS);
            phase_next    = PH_INT;
          end else if (is_digit) begin
            mantissa_next           = added_man;
            mantissa_saturated_next = added_sat;
            phase_next              = PH_INT;
          end else if (is_point) begin
            phase_next = PH_FRAC;
          end else begin
            start      = 1'b1;
            phase_next = PH_DONE;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            mantissa_next           = added_man;
            mantissa_saturated_next = added_sat;
          end else if (is_point) begin
            phase_next = PH_FRAC;
          end else begin
            start      = 1'b1;
            phase_next = PH_DONE;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            // Drop digits past the kept fraction length
            if (efd < FDIG_W'(MAX_FRACTION_DIGITS)) begin
              mantissa_next           = added_man;
              mantissa_saturated_next = added_sat;
              fraction_digits_next    = efd + 1'b1;
            end
          end else begin
            start      = 1'b1;
            phase_next = PH_DONE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_DONE;
      mantissa_saturated <= 1'b0;
    end else begin
      phase              <= phase_next;
      mantissa_saturated <= mantissa_saturated_next;
    end
    negative        <= negative_next;
    mantissa        <= mantissa_next;
    fraction_digits <= fraction_digits_next;
  end

  assign req = '{mantissa: eman, fdigits: efd, negative: eneg, saturated: esat};

  dtfx_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_divider (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (div_busy),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  a_sat_ones: assert property (@(posedge clk) disable iff (rst)
    (mantissa_saturated && phase != PH_DONE) |-> &mantissa)
    else $error("saturated mantissa not at full scale");
  a_start_ends: assert property (@(posedge clk) disable iff (rst)
    start |=> phase == PH_DONE)
    else $error("parser not done after ending character");
  a_fd_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FRAC |-> fraction_digits <= FDIG_W'(MAX_FRACTION_DIGITS))
    else $error("fraction digit count past limit");
`endif

endmodule
